// ----- hdl/tgr_pkg.sv -----
// Shared types, constants and a helper function for the touch gesture recognizer.
package tgr_pkg;

    localparam int COORD_BITS     = 12;
    localparam int TIMER_BITS     = 16;
    localparam int DELTA_BITS     = COORD_BITS + 1;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = (TIMER_BITS > COORD_BITS) ? TIMER_BITS : COORD_BITS;

    localparam logic [COORD_BITS-1:0] RST_MOVE_THRESHOLD = COORD_BITS'(25);
    localparam logic [TIMER_BITS-1:0] RST_TAP_WAIT_TICKS = TIMER_BITS'(200);
    localparam logic [TIMER_BITS-1:0] RST_HOLD_TICKS     = TIMER_BITS'(1000);

    typedef enum logic [1:0] {
        REQ_PRESS   = 2'd0,
        REQ_MOVE    = 2'd1,
        REQ_RELEASE = 2'd2,
        REQ_TICK    = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        G_SINGLE = 2'd0,
        G_DOUBLE = 2'd1,
        G_LONG   = 2'd2,
        G_DRAG   = 2'd3
    } gesture_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_MOVE_THRESHOLD_X = 2'd0,
        CFG_MOVE_THRESHOLD_Y = 2'd1,
        CFG_TAP_WAIT_TICKS   = 2'd2,
        CFG_HOLD_TICKS       = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_INITIAL = 3'd1,
        ST_PENDING = 3'd2,
        ST_LONG    = 3'd3,
        ST_SECOND  = 3'd4,
        ST_MOVING  = 3'd5
    } gesture_state_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] move_threshold_x;
        logic [COORD_BITS-1:0] move_threshold_y;
        logic [TIMER_BITS-1:0] tap_wait_ticks;
        logic [TIMER_BITS-1:0] hold_ticks;
    } tgr_cfg_t;

    typedef struct packed {
        gesture_state_t        gesture_state;
        logic [COORD_BITS-1:0] last_x;
        logic [COORD_BITS-1:0] last_y;
        logic [TIMER_BITS-1:0] tap_countdown;
        logic [TIMER_BITS-1:0] hold_countdown;
    } tgr_state_t;

    typedef struct packed {
        logic                         valid;
        gesture_t                     gesture_code;
        logic signed [DELTA_BITS-1:0] drag_dx;
        logic signed [DELTA_BITS-1:0] drag_dy;
    } tgr_result_t;

    function automatic logic [TIMER_BITS-1:0] load_value(input logic [TIMER_BITS-1:0] v);
        load_value = (v == '0) ? TIMER_BITS'(1) : v;
    endfunction

endpackage

// ----- hdl/tgr_req_if.sv -----
// Request channel: press, move, release or tick with a position.
interface tgr_req_if;
    logic                          valid;
    logic                          ready;
    tgr_pkg::req_kind_t            req_type;
    logic [tgr_pkg::COORD_BITS-1:0] pos_x;
    logic [tgr_pkg::COORD_BITS-1:0] pos_y;

    modport source (output valid, output req_type, output pos_x, output pos_y, input ready);
    modport sink   (input valid, input req_type, input pos_x, input pos_y, output ready);
endinterface

// ----- hdl/tgr_res_if.sv -----
// Result channel: recognized gesture with drag deltas.
interface tgr_res_if;
    logic                                 valid;
    logic                                 ready;
    tgr_pkg::gesture_t                    gesture_code;
    logic signed [tgr_pkg::DELTA_BITS-1:0] drag_dx;
    logic signed [tgr_pkg::DELTA_BITS-1:0] drag_dy;

    modport source (output valid, output gesture_code, output drag_dx, output drag_dy,
                    input ready);
    modport sink   (input valid, input gesture_code, input drag_dx, input drag_dy,
                    output ready);
endinterface

// ----- hdl/touch_gesture_recognizer.sv -----
// Top level of the touch gesture recognizer: registers, config port and result stage.
//
//   channel  direction  handshake         payload
//   req      in         valid / ready     req_type, pos_x, pos_y
//   res      out        valid / ready     gesture_code, drag_dx, drag_dy
//   cfg      in         cfg_we (no wait)  cfg_index, cfg_wdata
//
// One request per cycle; the state update is one combinational step into registers.
// A result lands in the output register in the cycle after its request and sits there.
// req.ready drops only while that register holds a result that res.ready does not take.
// Reset clears state, countdowns and positions and loads default configuration.
module touch_gesture_recognizer
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tgr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [tgr_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    tgr_req_if.sink                             req,
    tgr_res_if.source                           res
);

    tgr_pkg::tgr_cfg_t    cfg_reg;
    tgr_pkg::tgr_cfg_t    cfg_next;
    tgr_pkg::tgr_state_t  st_reg;
    tgr_pkg::tgr_state_t  st_next;
    tgr_pkg::tgr_result_t step_result;
    logic                 res_valid_reg;
    logic                 res_valid_next;
    tgr_pkg::gesture_t    res_code_reg;
    logic signed [tgr_pkg::DELTA_BITS-1:0] res_dx_reg;
    logic signed [tgr_pkg::DELTA_BITS-1:0] res_dy_reg;
    logic                 accept;
    logic                 out_free;

    tgr_step u_step
    (
        .st       (st_reg),
        .cfg      (cfg_reg),
        .req_type (req.req_type),
        .pos_x    (req.pos_x),
        .pos_y    (req.pos_y),
        .st_next  (st_next),
        .result   (step_result)
    );

    assign out_free  = !res_valid_reg || res.ready;
    assign req.ready = out_free;
    assign accept    = req.valid && out_free;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (tgr_pkg::cfg_index_t'(cfg_index))
                tgr_pkg::CFG_MOVE_THRESHOLD_X:
                    cfg_next.move_threshold_x = cfg_wdata[tgr_pkg::COORD_BITS-1:0];
                tgr_pkg::CFG_MOVE_THRESHOLD_Y:
                    cfg_next.move_threshold_y = cfg_wdata[tgr_pkg::COORD_BITS-1:0];
                tgr_pkg::CFG_TAP_WAIT_TICKS:
                    cfg_next.tap_wait_ticks = cfg_wdata[tgr_pkg::TIMER_BITS-1:0];
                tgr_pkg::CFG_HOLD_TICKS:
                    cfg_next.hold_ticks = cfg_wdata[tgr_pkg::TIMER_BITS-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        if (out_free)
        begin
            res_valid_next = accept && step_result.valid;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.move_threshold_x <= tgr_pkg::RST_MOVE_THRESHOLD;
            cfg_reg.move_threshold_y <= tgr_pkg::RST_MOVE_THRESHOLD;
            cfg_reg.tap_wait_ticks   <= tgr_pkg::RST_TAP_WAIT_TICKS;
            cfg_reg.hold_ticks       <= tgr_pkg::RST_HOLD_TICKS;
            st_reg.gesture_state     <= tgr_pkg::ST_IDLE;
            st_reg.last_x            <= '0;
            st_reg.last_y            <= '0;
            st_reg.tap_countdown     <= '0;
            st_reg.hold_countdown    <= '0;
            res_valid_reg            <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            res_valid_reg <= res_valid_next;
            if (accept)
            begin
                st_reg <= st_next;
            end
        end
    end

    // load result payload
    always_ff @(posedge clk)
    begin
        if (accept && step_result.valid)
        begin
            res_code_reg <= step_result.gesture_code;
            res_dx_reg   <= step_result.drag_dx;
            res_dy_reg   <= step_result.drag_dy;
        end
    end

    assign res.valid        = res_valid_reg;
    assign res.gesture_code = res_code_reg;
    assign res.drag_dx      = res_dx_reg;
    assign res.drag_dy      = res_dy_reg;

    a_nondrag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.gesture_code != tgr_pkg::G_DRAG |-> res.drag_dx == '0 && res.drag_dy == '0)
        else $error("non-drag result carries a nonzero delta");

    a_tap_only_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.tap_countdown != '0) == (st_reg.gesture_state == tgr_pkg::ST_PENDING))
        else $error("tap countdown out of step with pending state");

    a_hold_running: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.gesture_state == tgr_pkg::ST_INITIAL || st_reg.gesture_state == tgr_pkg::ST_SECOND
        |-> st_reg.hold_countdown != '0)
        else $error("touch state without a running hold countdown");

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        accept && step_result.valid |=> res.valid && res.gesture_code == $past(step_result.gesture_code))
        else $error("accepted request result not presented");

endmodule

// ----- hdl/tgr_step.sv -----
// Single-request gesture update: next state, countdowns and result.
module tgr_step
(
    input  tgr_pkg::tgr_state_t             st,
    input  tgr_pkg::tgr_cfg_t               cfg,
    input  tgr_pkg::req_kind_t              req_type,
    input  logic [tgr_pkg::COORD_BITS-1:0]  pos_x,
    input  logic [tgr_pkg::COORD_BITS-1:0]  pos_y,
    output tgr_pkg::tgr_state_t             st_next,
    output tgr_pkg::tgr_result_t            result
);

    tgr_pkg::gesture_state_t                 cur_state;
    logic signed [tgr_pkg::DELTA_BITS-1:0]   dx;
    logic signed [tgr_pkg::DELTA_BITS-1:0]   dy;
    logic [tgr_pkg::DELTA_BITS-1:0]          dx_mag;
    logic [tgr_pkg::DELTA_BITS-1:0]          dy_mag;
    logic                                    exceeds;
    logic                                    drag_go;
    logic                                    hold_expire;
    logic                                    tap_expire;

    assign cur_state = (st.gesture_state > tgr_pkg::ST_MOVING) ? tgr_pkg::ST_IDLE
                                                               : st.gesture_state;

    assign dx     = signed'({1'b0, pos_x}) - signed'({1'b0, st.last_x});
    assign dy     = signed'({1'b0, pos_y}) - signed'({1'b0, st.last_y});
    assign dx_mag = dx[tgr_pkg::DELTA_BITS-1] ? unsigned'(-dx) : unsigned'(dx);
    assign dy_mag = dy[tgr_pkg::DELTA_BITS-1] ? unsigned'(-dy) : unsigned'(dy);

    assign exceeds = (dx_mag > {1'b0, cfg.move_threshold_x}) ||
                     (dy_mag > {1'b0, cfg.move_threshold_y});

    always_comb
    begin
        case (cur_state)
            tgr_pkg::ST_INITIAL, tgr_pkg::ST_SECOND: drag_go = exceeds;
            tgr_pkg::ST_LONG, tgr_pkg::ST_MOVING:    drag_go = 1'b1;
            default:                                 drag_go = 1'b0;
        endcase
    end

    assign hold_expire = (st.hold_countdown == tgr_pkg::TIMER_BITS'(1));
    assign tap_expire  = (st.tap_countdown == tgr_pkg::TIMER_BITS'(1));

    // next state and countdowns
    always_comb
    begin
        st_next               = st;
        st_next.gesture_state = cur_state;
        case (req_type)
            tgr_pkg::REQ_PRESS:
            begin
                st_next.last_x = pos_x;
                st_next.last_y = pos_y;
                if (cur_state == tgr_pkg::ST_IDLE)
                begin
                    st_next.hold_countdown = tgr_pkg::load_value(cfg.hold_ticks);
                    st_next.gesture_state  = tgr_pkg::ST_INITIAL;
                end
                else if (cur_state == tgr_pkg::ST_PENDING)
                begin
                    st_next.tap_countdown  = '0;
                    st_next.hold_countdown = tgr_pkg::load_value(cfg.hold_ticks);
                    st_next.gesture_state  = tgr_pkg::ST_SECOND;
                end
            end
            tgr_pkg::REQ_MOVE:
            begin
                if (drag_go)
                begin
                    st_next.gesture_state = tgr_pkg::ST_MOVING;
                    st_next.last_x        = pos_x;
                    st_next.last_y        = pos_y;
                end
            end
            tgr_pkg::REQ_RELEASE:
            begin
                case (cur_state)
                    tgr_pkg::ST_INITIAL:
                    begin
                        st_next.hold_countdown = '0;
                        st_next.tap_countdown  = tgr_pkg::load_value(cfg.tap_wait_ticks);
                        st_next.gesture_state  = tgr_pkg::ST_PENDING;
                    end
                    tgr_pkg::ST_SECOND:
                    begin
                        st_next.hold_countdown = '0;
                        st_next.gesture_state  = tgr_pkg::ST_IDLE;
                    end
                    tgr_pkg::ST_LONG, tgr_pkg::ST_MOVING:
                    begin
                        st_next.gesture_state = tgr_pkg::ST_IDLE;
                    end
                    default:
                    begin
                        st_next.gesture_state = cur_state;
                    end
                endcase
            end
            tgr_pkg::REQ_TICK:
            begin
                if (st.hold_countdown != '0)
                begin
                    st_next.hold_countdown = st.hold_countdown - tgr_pkg::TIMER_BITS'(1);
                    if (hold_expire && (cur_state == tgr_pkg::ST_INITIAL ||
                                        cur_state == tgr_pkg::ST_SECOND))
                    begin
                        st_next.gesture_state = tgr_pkg::ST_LONG;
                    end
                end
                if (st.tap_countdown != '0)
                begin
                    st_next.tap_countdown = st.tap_countdown - tgr_pkg::TIMER_BITS'(1);
                    if (tap_expire && cur_state == tgr_pkg::ST_PENDING)
                    begin
                        st_next.gesture_state = tgr_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                st_next = st;
            end
        endcase
    end

    // result
    always_comb
    begin
        result.valid        = 1'b0;
        result.gesture_code = tgr_pkg::G_SINGLE;
        result.drag_dx      = '0;
        result.drag_dy      = '0;
        case (req_type)
            tgr_pkg::REQ_MOVE:
            begin
                if (drag_go)
                begin
                    result.valid        = 1'b1;
                    result.gesture_code = tgr_pkg::G_DRAG;
                    result.drag_dx      = dx;
                    result.drag_dy      = dy;
                end
            end
            tgr_pkg::REQ_RELEASE:
            begin
                if (cur_state == tgr_pkg::ST_SECOND)
                begin
                    result.valid        = 1'b1;
                    result.gesture_code = tgr_pkg::G_DOUBLE;
                end
                else if (cur_state == tgr_pkg::ST_LONG)
                begin
                    result.valid        = 1'b1;
                    result.gesture_code = tgr_pkg::G_LONG;
                end
            end
            tgr_pkg::REQ_TICK:
            begin
                if (tap_expire && cur_state == tgr_pkg::ST_PENDING)
                begin
                    result.valid        = 1'b1;
                    result.gesture_code = tgr_pkg::G_SINGLE;
                end
            end
            default:
            begin
                result.valid = 1'b0;
            end
        endcase
    end

endmodule

// ----- test/tgr_checker.sv -----
`timescale 1ns / 100ps
// Gesture checker: predicts the recognizer's gestures from accepted requests and compares results.
module tgr_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [tgr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [tgr_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    tgr_req_if                                 req,
    tgr_res_if                                 res,
    output int                                 mismatches,
    output int                                 pending
);

    typedef struct packed {
        tgr_pkg::gesture_t                     code;
        logic signed [tgr_pkg::DELTA_BITS-1:0] dx;
        logic signed [tgr_pkg::DELTA_BITS-1:0] dy;
    } gesture_event_t;

    gesture_event_t                 awaited_gestures[$];

    tgr_pkg::gesture_state_t        track_state;
    logic [tgr_pkg::COORD_BITS-1:0] last_x;
    logic [tgr_pkg::COORD_BITS-1:0] last_y;
    logic [tgr_pkg::TIMER_BITS-1:0] tap_left;
    logic [tgr_pkg::TIMER_BITS-1:0] hold_left;
    logic [tgr_pkg::COORD_BITS-1:0] thr_x;
    logic [tgr_pkg::COORD_BITS-1:0] thr_y;
    logic [tgr_pkg::TIMER_BITS-1:0] tap_wait;
    logic [tgr_pkg::TIMER_BITS-1:0] hold_len;

    function automatic logic [tgr_pkg::TIMER_BITS-1:0] arm_timer(
        input logic [tgr_pkg::TIMER_BITS-1:0] ticks);
        return (ticks == '0) ? tgr_pkg::TIMER_BITS'(1) : ticks;
    endfunction

    function automatic int magnitude(input int v);
        return (v < 0) ? -v : v;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t gesture mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic await_gesture(input tgr_pkg::gesture_t code, input int dx, input int dy);
        gesture_event_t ev;
        ev.code = code;
        ev.dx   = tgr_pkg::DELTA_BITS'(dx);
        ev.dy   = tgr_pkg::DELTA_BITS'(dy);
        awaited_gestures.push_back(ev);
    endtask

    task automatic classify_request(input tgr_pkg::req_kind_t kind,
                                    input logic [tgr_pkg::COORD_BITS-1:0] x,
                                    input logic [tgr_pkg::COORD_BITS-1:0] y);
        int   dx;
        int   dy;
        logic drag;
        dx   = int'(x) - int'(last_x);
        dy   = int'(y) - int'(last_y);
        drag = 1'b0;
        case (kind)
            tgr_pkg::REQ_PRESS:
            begin
                last_x = x;
                last_y = y;
                if (track_state == tgr_pkg::ST_IDLE)
                begin
                    hold_left   = arm_timer(hold_len);
                    track_state = tgr_pkg::ST_INITIAL;
                end
                else if (track_state == tgr_pkg::ST_PENDING)
                begin
                    tap_left    = '0;
                    hold_left   = arm_timer(hold_len);
                    track_state = tgr_pkg::ST_SECOND;
                end
            end
            tgr_pkg::REQ_MOVE:
            begin
                if (track_state == tgr_pkg::ST_INITIAL || track_state == tgr_pkg::ST_SECOND)
                    drag = (magnitude(dx) > int'(thr_x)) || (magnitude(dy) > int'(thr_y));
                else if (track_state == tgr_pkg::ST_LONG || track_state == tgr_pkg::ST_MOVING)
                    drag = 1'b1;
                if (drag)
                begin
                    track_state = tgr_pkg::ST_MOVING;
                    last_x      = x;
                    last_y      = y;
                    await_gesture(tgr_pkg::G_DRAG, dx, dy);
                end
            end
            tgr_pkg::REQ_RELEASE:
            begin
                case (track_state)
                    tgr_pkg::ST_INITIAL:
                    begin
                        hold_left   = '0;
                        tap_left    = arm_timer(tap_wait);
                        track_state = tgr_pkg::ST_PENDING;
                    end
                    tgr_pkg::ST_SECOND:
                    begin
                        hold_left   = '0;
                        track_state = tgr_pkg::ST_IDLE;
                        await_gesture(tgr_pkg::G_DOUBLE, 0, 0);
                    end
                    tgr_pkg::ST_LONG:
                    begin
                        track_state = tgr_pkg::ST_IDLE;
                        await_gesture(tgr_pkg::G_LONG, 0, 0);
                    end
                    tgr_pkg::ST_MOVING:
                        track_state = tgr_pkg::ST_IDLE;
                    default:
                        ;
                endcase
            end
            default:
            begin
                if (hold_left != '0)
                begin
                    hold_left = hold_left - tgr_pkg::TIMER_BITS'(1);
                    if (hold_left == '0 &&
                        (track_state == tgr_pkg::ST_INITIAL ||
                         track_state == tgr_pkg::ST_SECOND))
                        track_state = tgr_pkg::ST_LONG;
                end
                if (tap_left != '0)
                begin
                    tap_left = tap_left - tgr_pkg::TIMER_BITS'(1);
                    if (tap_left == '0 && track_state == tgr_pkg::ST_PENDING)
                    begin
                        track_state = tgr_pkg::ST_IDLE;
                        await_gesture(tgr_pkg::G_SINGLE, 0, 0);
                    end
                end
            end
        endcase
    endtask

    task automatic compare_gesture();
        gesture_event_t want;
        if (awaited_gestures.size() == 0)
        begin
            report_mismatch($sformatf("unexpected gesture %0d dx %0d dy %0d",
                                      res.gesture_code, res.drag_dx, res.drag_dy));
            return;
        end
        want = awaited_gestures.pop_front();
        if (res.gesture_code !== want.code)
            report_mismatch($sformatf("gesture_code %0d, want %0d", res.gesture_code, want.code));
        if (res.drag_dx !== want.dx)
            report_mismatch($sformatf("drag_dx %0d, want %0d", res.drag_dx, want.dx));
        if (res.drag_dy !== want.dy)
            report_mismatch($sformatf("drag_dy %0d, want %0d", res.drag_dy, want.dy));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaited_gestures.delete();
            track_state = tgr_pkg::ST_IDLE;
            last_x      = '0;
            last_y      = '0;
            tap_left    = '0;
            hold_left   = '0;
            thr_x       = tgr_pkg::RST_MOVE_THRESHOLD;
            thr_y       = tgr_pkg::RST_MOVE_THRESHOLD;
            tap_wait    = tgr_pkg::RST_TAP_WAIT_TICKS;
            hold_len    = tgr_pkg::RST_HOLD_TICKS;
            mismatches  = 0;
            pending     = 0;
        end
        else
        begin
            if (res.valid && res.ready)
                compare_gesture();
            if (cfg_we)
            begin
                case (tgr_pkg::cfg_index_t'(cfg_index))
                    tgr_pkg::CFG_MOVE_THRESHOLD_X:
                        thr_x = cfg_wdata[tgr_pkg::COORD_BITS-1:0];
                    tgr_pkg::CFG_MOVE_THRESHOLD_Y:
                        thr_y = cfg_wdata[tgr_pkg::COORD_BITS-1:0];
                    tgr_pkg::CFG_TAP_WAIT_TICKS:
                        tap_wait = cfg_wdata[tgr_pkg::TIMER_BITS-1:0];
                    tgr_pkg::CFG_HOLD_TICKS:
                        hold_len = cfg_wdata[tgr_pkg::TIMER_BITS-1:0];
                    default:
                        ;
                endcase
            end
            if (req.valid && req.ready)
                classify_request(req.req_type, req.pos_x, req.pos_y);
            pending = awaited_gestures.size();
        end
    end

endmodule

// ----- test/tb_touch_gesture_recognizer.sv -----
`timescale 1ns / 100ps
// Testbench top for the touch gesture recognizer: clock, reset, touch stimulus and verdict.
module tb_touch_gesture_recognizer;

    localparam int COORD_MAX    = (1 << tgr_pkg::COORD_BITS) - 1;
    localparam int TICK_CAP     = 24;
    localparam int RANDOM_ITEMS = 1450;
    localparam int PHASES       = 6;
    localparam int CYCLE_LIMIT  = 400000;

    logic                               clk   = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               cfg_we;
    logic [tgr_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [tgr_pkg::CFG_DATA_BITS-1:0]  cfg_wdata;
    int                                 mismatches;
    int                                 pending;

    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int stall_cycles = 0;
    int sent         = 0;
    int cycles       = 0;
    int cur_thr_x    = 25;
    int cur_thr_y    = 25;
    int cur_tap      = 200;
    int cur_hold     = 1000;

    tgr_req_if req_ch();
    tgr_res_if res_ch();

    touch_gesture_recognizer DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .res       (res_ch)
    );

    tgr_checker gesture_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .req        (req_ch),
        .res        (res_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb_touch_gesture_recognizer failed");
            $finish;
        end
    end

    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_cycles > 0)
            begin
                res_ch.ready <= 1'b0;
                stall_cycles--;
            end
            else
                res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic logic [tgr_pkg::COORD_BITS-1:0] coord(input int v);
        return tgr_pkg::COORD_BITS'(v);
    endfunction

    function automatic logic [tgr_pkg::CFG_DATA_BITS-1:0] cfg_word(input int v);
        return tgr_pkg::CFG_DATA_BITS'(v);
    endfunction

    function automatic logic [tgr_pkg::COORD_BITS-1:0] rand_coord();
        return tgr_pkg::COORD_BITS'($urandom_range(COORD_MAX));
    endfunction

    function automatic logic [tgr_pkg::COORD_BITS-1:0] nudge(
        input logic [tgr_pkg::COORD_BITS-1:0] v,
        input int                             thr);
        int span;
        int p;
        span = (thr + 2 > COORD_MAX) ? COORD_MAX : thr + 2;
        p    = int'(v) + int'($urandom_range(2 * span)) - span;
        if (p < 0)
            p = 0;
        if (p > COORD_MAX)
            p = COORD_MAX;
        return tgr_pkg::COORD_BITS'(p);
    endfunction

    function automatic int tick_span(input int v);
        return (v > TICK_CAP) ? TICK_CAP : v;
    endfunction

    task automatic send(input tgr_pkg::req_kind_t kind,
                        input logic [tgr_pkg::COORD_BITS-1:0] x,
                        input logic [tgr_pkg::COORD_BITS-1:0] y);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.pos_x    <= x;
        req_ch.pos_y    <= y;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sent++;
    endtask

    task automatic tick_run(input int n);
        repeat (n) send(tgr_pkg::REQ_TICK, rand_coord(), rand_coord());
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic load_config(input logic [tgr_pkg::CFG_DATA_BITS-1:0] thr_x,
                               input logic [tgr_pkg::CFG_DATA_BITS-1:0] thr_y,
                               input logic [tgr_pkg::CFG_DATA_BITS-1:0] tap,
                               input logic [tgr_pkg::CFG_DATA_BITS-1:0] hold);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= tgr_pkg::CFG_MOVE_THRESHOLD_X;
        cfg_wdata <= thr_x;
        @(posedge clk);
        cfg_index <= tgr_pkg::CFG_MOVE_THRESHOLD_Y;
        cfg_wdata <= thr_y;
        @(posedge clk);
        cfg_index <= tgr_pkg::CFG_TAP_WAIT_TICKS;
        cfg_wdata <= tap;
        @(posedge clk);
        cfg_index <= tgr_pkg::CFG_HOLD_TICKS;
        cfg_wdata <= hold;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_thr_x = int'(thr_x[tgr_pkg::COORD_BITS-1:0]);
        cur_thr_y = int'(thr_y[tgr_pkg::COORD_BITS-1:0]);
        cur_tap   = (tap[tgr_pkg::TIMER_BITS-1:0] == '0) ? 1
                                                         : int'(tap[tgr_pkg::TIMER_BITS-1:0]);
        cur_hold  = (hold[tgr_pkg::TIMER_BITS-1:0] == '0) ? 1
                                                          : int'(hold[tgr_pkg::TIMER_BITS-1:0]);
    endtask

    task automatic random_gesture();
        int                             pick;
        logic [tgr_pkg::COORD_BITS-1:0] x;
        logic [tgr_pkg::COORD_BITS-1:0] y;
        pick = $urandom_range(99);
        x    = rand_coord();
        y    = rand_coord();
        if (pick < 15)
        begin
            repeat ($urandom_range(1, 3))
                send(tgr_pkg::req_kind_t'($urandom_range(3)), rand_coord(), rand_coord());
            return;
        end
        send(tgr_pkg::REQ_PRESS, x, y);
        if (pick < 45)
        begin
            repeat ($urandom_range(2))
                send(tgr_pkg::REQ_MOVE, nudge(x, cur_thr_x), nudge(y, cur_thr_y));
            send(tgr_pkg::REQ_RELEASE, rand_coord(), rand_coord());
            if ($urandom_range(1) == 0)
                tick_run($urandom_range(tick_span(cur_tap) + 1));
            else
            begin
                tick_run($urandom_range(tick_span(cur_tap) - 1));
                send(tgr_pkg::REQ_PRESS, nudge(x, cur_thr_x), nudge(y, cur_thr_y));
                repeat ($urandom_range(1))
                    send(tgr_pkg::REQ_MOVE, nudge(x, cur_thr_x), nudge(y, cur_thr_y));
                tick_run($urandom_range(tick_span(cur_hold) + 1));
                send(tgr_pkg::REQ_RELEASE, rand_coord(), rand_coord());
            end
        end
        else if (pick < 70)
        begin
            tick_run($urandom_range(tick_span(cur_hold) - 1, tick_span(cur_hold) + 2));
            repeat ($urandom_range(2))
            begin
                if ($urandom_range(1) == 0)
                    send(tgr_pkg::REQ_MOVE, rand_coord(), rand_coord());
                else
                    send(tgr_pkg::REQ_MOVE, nudge(x, cur_thr_x), nudge(y, cur_thr_y));
            end
            send(tgr_pkg::REQ_RELEASE, rand_coord(), rand_coord());
            tick_run($urandom_range(2));
        end
        else
        begin
            send(tgr_pkg::REQ_MOVE, rand_coord(), rand_coord());
            repeat ($urandom_range(4))
                send(tgr_pkg::REQ_MOVE, nudge(x, 400), nudge(y, 400));
            tick_run($urandom_range(3));
            send(tgr_pkg::REQ_MOVE, rand_coord(), rand_coord());
            send(tgr_pkg::REQ_RELEASE, rand_coord(), rand_coord());
        end
    endtask

    initial
    begin
        int phase;
        int base;
        int mid;
        int goal;

        req_ch.valid    <= 1'b0;
        req_ch.req_type <= tgr_pkg::REQ_PRESS;
        req_ch.pos_x    <= '0;
        req_ch.pos_y    <= '0;
        cfg_we          <= 1'b0;
        cfg_index       <= tgr_pkg::CFG_MOVE_THRESHOLD_X;
        cfg_wdata       <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 31;
        rx_idle_pct = 87;
        load_config(cfg_word(25), cfg_word(25), cfg_word(2), cfg_word(3));

        send(tgr_pkg::REQ_PRESS, coord(0), coord(0));
        send(tgr_pkg::REQ_MOVE, coord(25), coord(0));
        send(tgr_pkg::REQ_RELEASE, coord(0), coord(0));
        tick_run(2);
        send(tgr_pkg::REQ_PRESS, coord(COORD_MAX), coord(COORD_MAX));
        send(tgr_pkg::REQ_RELEASE, coord(COORD_MAX), coord(COORD_MAX));
        send(tgr_pkg::REQ_PRESS, coord(COORD_MAX), coord(COORD_MAX));
        send(tgr_pkg::REQ_RELEASE, coord(COORD_MAX), coord(COORD_MAX));
        send(tgr_pkg::REQ_PRESS, coord(100), coord(100));
        tick_run(3);
        send(tgr_pkg::REQ_MOVE, coord(COORD_MAX), coord(0));
        send(tgr_pkg::REQ_MOVE, coord(0), coord(COORD_MAX));
        send(tgr_pkg::REQ_RELEASE, coord(0), coord(0));
        send(tgr_pkg::REQ_PRESS, coord(2048), coord(2048));
        tick_run(3);
        send(tgr_pkg::REQ_RELEASE, coord(0), coord(0));
        send(tgr_pkg::REQ_PRESS, coord(0), coord(0));
        send(tgr_pkg::REQ_MOVE, coord(0), coord(26));
        send(tgr_pkg::REQ_RELEASE, coord(0), coord(0));
        send(tgr_pkg::REQ_RELEASE, coord(0), coord(0));
        send(tgr_pkg::REQ_MOVE, coord(COORD_MAX), coord(COORD_MAX));
        send(tgr_pkg::REQ_TICK, coord(COORD_MAX), coord(COORD_MAX));

        base = sent;
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    load_config(tgr_pkg::CFG_DATA_BITS'($urandom_range(5, 120)),
                                tgr_pkg::CFG_DATA_BITS'($urandom_range(5, 120)),
                                tgr_pkg::CFG_DATA_BITS'($urandom_range(1, 6)),
                                tgr_pkg::CFG_DATA_BITS'($urandom_range(2, 10)));
                    stall_cycles = 300;
                end
                1:
                    load_config(cfg_word(0), cfg_word(0), cfg_word(0), cfg_word(0));
                2:
                begin
                    tx_idle_pct = 87;
                    rx_idle_pct = 31;
                    load_config('1, '1, '1, '1);
                end
                3:
                    load_config(tgr_pkg::CFG_DATA_BITS'($urandom),
                                tgr_pkg::CFG_DATA_BITS'($urandom_range(60)),
                                tgr_pkg::CFG_DATA_BITS'($urandom_range(1, 4)),
                                tgr_pkg::CFG_DATA_BITS'($urandom_range(1, 6)));
                4:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    load_config(tgr_pkg::CFG_DATA_BITS'($urandom_range(300)),
                                tgr_pkg::CFG_DATA_BITS'($urandom_range(300)),
                                tgr_pkg::CFG_DATA_BITS'($urandom_range(1, 8)),
                                tgr_pkg::CFG_DATA_BITS'($urandom_range(1, 12)));
                end
                default:
                    load_config(cfg_word(1), cfg_word(COORD_MAX - 1), cfg_word(1), cfg_word(1));
            endcase
            mid  = base + (2 * phase + 1) * RANDOM_ITEMS / (2 * PHASES);
            goal = base + (phase + 1) * RANDOM_ITEMS / PHASES;
            while (sent < mid)
                random_gesture();
            drain_results();
            while (sent < goal)
                random_gesture();
        end

        drain_results();
        if (mismatches == 0 && pending == 0)
            $display("tb_touch_gesture_recognizer passed");
        else
            $display("tb_touch_gesture_recognizer failed");
        $finish;
    end

endmodule
